/* hw/rtl/nrmc_pkg.sv */
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared types, character codes and helpers for the GPRMC sentence parser.
// ----------------------------------------------------------------------------
package nrmc_pkg;

	localparam int FIELD_CHARS_DEF = 16;
	localparam int NUM_FIELDS      = 13;
	localparam int NUM_BANKS       = 2;
	localparam int NUM_ENTRIES     = NUM_BANKS * NUM_FIELDS;
	localparam int HDR_LEN         = 6;
	localparam int MIN_COMMAS      = 11;
	localparam int MAX_COMMAS      = 12;
	localparam int LEN_W           = 5;
	localparam int ENTRY_W         = 5;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef enum logic [1:0] {
		OUT_OK       = 2'd0,
		OUT_BAD_HDR  = 2'd1,
		OUT_COMMAS   = 2'd2,
		OUT_OVERFLOW = 2'd3
	} outcome_t;

	// store request from the parser
	typedef struct packed {
		logic             we;
		logic [3:0]       field;
		logic [LEN_W-1:0] len;
	} wr_req_t;

	// sentence end report
	typedef struct packed {
		logic       done;
		outcome_t   outcome;
		logic [3:0] commas;
	} status_t;

	// result carried alongside the memory read
	typedef struct packed {
		logic       kind;
		outcome_t   outcome;
		logic [3:0] commas;
		logic [3:0] csel;
		logic       len_ok;
		logic       ch_ok;
	} res_info_t;

	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = CH_DOLLAR;
			3'd1: c = CH_G;
			3'd2: c = CH_P;
			3'd3: c = CH_R;
			3'd4: c = CH_M;
			3'd5: c = CH_C;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// status, N/S, E/W, variation direction, mode
	function automatic logic single_char_field(input logic [3:0] f);
		return (f == 4'd2) || (f == 4'd4) || (f == 4'd6) || (f == 4'd11) || (f == 4'd12);
	endfunction

	function automatic logic [ENTRY_W-1:0] entry_idx(input logic bank, input logic [3:0] f);
		return bank ? (ENTRY_W'(f) + ENTRY_W'(NUM_FIELDS)) : ENTRY_W'(f);
	endfunction

endpackage

/* hw/rtl/nmea_rmc_sentence_parser.sv */
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser
// GPRMC sentence parser with double-banked field storage in RAM.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | input     | in_valid/in_stall  | action, byte_in, field_sel, char_sel
//  out     | output    | out_valid/out_stall| kind, outcome, commas_seen,
//          |           |                    | char_out, field_length
//
// One request per cycle while in_stall is low. A read result passes the RAM read
// register, then the output register; a sentence end status takes the same path.
// Reset clears parser state and the field length valid bits; no clearing pass.
// in_stall rises only while a result waits in the read stage behind a stalled
// output register.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser import nrmc_pkg::*; #(
	parameter int FIELD_CHARS = FIELD_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] byte_in,
	input  logic [3:0] field_sel,
	input  logic [3:0] char_sel,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [1:0] outcome,
	output logic [3:0] commas_seen,
	output logic [7:0] char_out,
	output logic [4:0] field_length
);

	localparam int POS_W   = $clog2(FIELD_CHARS + 1);
	localparam int F_DEPTH = NUM_ENTRIES * FIELD_CHARS;
	localparam int F_AW    = $clog2(F_DEPTH);

	logic             accept, push_en, rd_en, rd_fok, rd_cok;
	wr_req_t          wr;
	logic [POS_W-1:0] wr_pos;
	logic             clr_work;
	status_t          status;
	logic             cbank;
	logic [ENTRY_W-1:0] wr_entry, rd_entry;
	logic [NUM_ENTRIES-1:0] lvalid_q;
	logic [F_AW-1:0]  f_waddr, f_raddr;
	logic             f_re, l_re;
	logic [7:0]       ram_ch;
	logic [LEN_W-1:0] ram_len;
	res_info_t        info;
	logic             hold;

	assign in_stall = hold;
	assign accept   = in_valid && !in_stall;
	assign push_en  = accept && (action == ACT_PUSH);
	assign rd_en    = accept && (action == ACT_READ);
	assign rd_fok   = field_sel < 4'(NUM_FIELDS);
	assign rd_cok   = int'(char_sel) < FIELD_CHARS;

	nrmc_ctrl #(
		.FIELD_CHARS(FIELD_CHARS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_en  (push_en),
		.byte_in  (byte_in),
		.wr       (wr),
		.wr_pos   (wr_pos),
		.clr_work (clr_work),
		.status   (status),
		.cbank    (cbank)
	);

	// writes go to the working bank, reads to the committed one
	assign wr_entry = entry_idx(~cbank, wr.field);
	assign rd_entry = entry_idx(cbank, field_sel);
	assign f_waddr  = F_AW'(wr_entry) * F_AW'(FIELD_CHARS) + F_AW'(wr_pos);
	assign f_raddr  = F_AW'(rd_entry) * F_AW'(FIELD_CHARS) + F_AW'(char_sel);
	assign f_re     = rd_en && rd_fok && rd_cok;
	assign l_re     = rd_en && rd_fok;

	nrmc_ram #(
		.WIDTH(8),
		.DEPTH(F_DEPTH)
	) u_field_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (f_waddr),
		.wdata (byte_in),
		.re    (f_re),
		.raddr (f_raddr),
		.rdata (ram_ch)
	);

	nrmc_ram #(
		.WIDTH(LEN_W),
		.DEPTH(NUM_ENTRIES)
	) u_len_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr_entry),
		.wdata (wr.len),
		.re    (l_re),
		.raddr (rd_entry),
		.rdata (ram_len)
	);

	// length valid bits: a cleared entry reads as length zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvalid_q <= '0;
		end else begin
			if (clr_work) begin
				for (int f = 0; f < NUM_FIELDS; f++) begin
					lvalid_q[entry_idx(~cbank, 4'(f))] <= 1'b0;
				end
			end
			if (wr.we) begin
				lvalid_q[wr_entry] <= 1'b1;
			end
		end
	end

	always_comb begin
		info.kind    = rd_en ? KIND_READ : KIND_STATUS;
		info.outcome = status.outcome;
		info.commas  = status.commas;
		info.csel    = char_sel;
		info.len_ok  = rd_fok && lvalid_q[rd_entry];
		info.ch_ok   = rd_cok;
	end

	nrmc_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (rd_en || status.done),
		.info         (info),
		.ram_ch       (ram_ch),
		.ram_len      (ram_len),
		.hold         (hold),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.outcome      (outcome),
		.commas_seen  (commas_seen),
		.char_out     (char_out),
		.field_length (field_length)
	);

`ifndef SYNTHESIS
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we && f_re |-> f_waddr != f_raddr)
		else $error("field RAM read and write hit the same entry");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS |-> char_out == 8'h00 && field_length == 5'd0
			&& commas_seen <= 4'(NUM_FIELDS))
		else $error("status result carries read data");

	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_READ |-> outcome == OUT_OK && commas_seen == 4'd0)
		else $error("read result carries status data");
`endif

endmodule

/* hw/rtl/nrmc_ram.sv */
// ----------------------------------------------------------------------------
// nrmc_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module nrmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/nrmc_ctrl.sv */
// ----------------------------------------------------------------------------
// nrmc_ctrl
// Sentence tracker: header check, comma count, character position, error
// latch and bank select. Issues store requests into the working bank.
// ----------------------------------------------------------------------------
module nrmc_ctrl import nrmc_pkg::*; #(
	parameter int FIELD_CHARS = FIELD_CHARS_DEF,
	localparam int POS_W = $clog2(FIELD_CHARS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_en,
	input  logic [7:0]       byte_in,
	output wr_req_t          wr,
	output logic [POS_W-1:0] wr_pos,
	output logic             clr_work,
	output status_t          status,
	output logic             cbank
);

	logic             ins_q, ins_d;
	logic [3:0]       cf_q, cf_d;
	logic [POS_W-1:0] pos_q, pos_d;
	outcome_t         err_q, err_d;
	logic             cb_q, cb_d;

	logic     hdr_short;
	outcome_t err_hdr;
	outcome_t err_tmp;
	outcome_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_q <= 1'b0;
			cf_q  <= '0;
			pos_q <= '0;
			err_q <= OUT_OK;
			cb_q  <= 1'b0;
		end else begin
			ins_q <= ins_d;
			cf_q  <= cf_d;
			pos_q <= pos_d;
			err_q <= err_d;
			cb_q  <= cb_d;
		end
	end

	always_comb begin
		ins_d    = ins_q;
		cf_d     = cf_q;
		pos_d    = pos_q;
		err_d    = err_q;
		cb_d     = cb_q;
		wr.we    = 1'b0;
		wr.field = cf_q;
		wr.len   = LEN_W'(1);
		wr_pos   = '0;
		clr_work = 1'b0;
		status.done    = 1'b0;
		status.outcome = OUT_OK;
		status.commas  = cf_q;
		err_tmp  = err_q;
		res      = OUT_OK;

		// header ended before six characters
		hdr_short = (cf_q == 4'd0) && (pos_q < POS_W'(HDR_LEN));
		err_hdr   = (err_q == OUT_OK && hdr_short) ? OUT_BAD_HDR : err_q;

		if (push_en) begin
			if (byte_in == CH_DOLLAR) begin
				clr_work = 1'b1;
				ins_d    = 1'b1;
				cf_d     = '0;
				pos_d    = POS_W'(1);
				err_d    = OUT_OK;
				wr.we    = 1'b1;
				wr.field = '0;
			end else if (ins_q) begin
				case (byte_in)
					CH_COMMA: begin
						err_tmp = err_hdr;
						if (cf_q >= 4'(NUM_FIELDS - 1)) begin
							if (err_tmp == OUT_OK) begin
								err_tmp = OUT_COMMAS;
							end
							cf_d = 4'(NUM_FIELDS);
						end else begin
							cf_d = cf_q + 4'd1;
						end
						err_d = err_tmp;
						pos_d = '0;
					end
					CH_STAR: begin
						if (err_hdr != OUT_OK) begin
							res = err_hdr;
						end else if (cf_q != 4'(MIN_COMMAS) && cf_q != 4'(MAX_COMMAS)) begin
							res = OUT_COMMAS;
						end else begin
							res = OUT_OK;
						end
						if (res == OUT_OK) begin
							cb_d = ~cb_q;
						end
						status.done    = 1'b1;
						status.outcome = res;
						ins_d = 1'b0;
						cf_d  = '0;
						pos_d = '0;
						err_d = OUT_OK;
					end
					default: begin
						if (cf_q < 4'(NUM_FIELDS)) begin
							if (single_char_field(cf_q)) begin
								wr.we = 1'b1;
								pos_d = POS_W'(1);
							end else begin
								if (cf_q == 4'd0 && err_tmp == OUT_OK &&
								    (pos_q >= POS_W'(HDR_LEN) || byte_in != hdr_char(pos_q[2:0]))) begin
									err_tmp = OUT_BAD_HDR;
								end
								if (pos_q >= POS_W'(FIELD_CHARS)) begin
									if (err_tmp == OUT_OK) begin
										err_tmp = OUT_OVERFLOW;
									end
								end else begin
									wr.we  = 1'b1;
									wr_pos = pos_q;
									wr.len = LEN_W'(pos_q + POS_W'(1));
									pos_d  = pos_q + POS_W'(1);
								end
								err_d = err_tmp;
							end
						end
					end
				endcase
			end
		end
	end

	assign cbank = cb_q;

endmodule

/* hw/rtl/nrmc_out.sv */
// ----------------------------------------------------------------------------
// nrmc_out
// Result stage: holds the item whose memory read is in flight, masks the read
// data by length and drives the output register.
// ----------------------------------------------------------------------------
module nrmc_out import nrmc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  res_info_t        info,
	input  logic [7:0]       ram_ch,
	input  logic [LEN_W-1:0] ram_len,
	output logic             hold,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             kind,
	output logic [1:0]       outcome,
	output logic [3:0]       commas_seen,
	output logic [7:0]       char_out,
	output logic [4:0]       field_length
);

	logic       v_s1;
	res_info_t  info_s1;
	logic       move;
	logic [LEN_W-1:0] len_c;
	logic [7:0]       ch_c;

	assign move = v_s1 && (!out_valid || !out_stall);
	// memory read data would be lost if a new request entered now
	assign hold = v_s1 && !move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= load || (v_s1 && !move);
			if (move) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			info_s1 <= info;
		end
	end

	always_comb begin
		len_c = info_s1.len_ok ? ram_len : '0;
		ch_c  = (info_s1.ch_ok && (LEN_W'(info_s1.csel) < len_c)) ? ram_ch : 8'h00;
	end

	always_ff @(posedge clk) begin
		if (move) begin
			kind <= info_s1.kind;
			if (info_s1.kind == KIND_READ) begin
				outcome      <= OUT_OK;
				commas_seen  <= '0;
				char_out     <= ch_c;
				field_length <= len_c;
			end else begin
				outcome      <= info_s1.outcome;
				commas_seen  <= info_s1.commas;
				char_out     <= 8'h00;
				field_length <= '0;
			end
		end
	end

endmodule

/* tb/nmea_rmc_sentence_parser_tb.sv */
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser_tb
// Self-checking bench for the GPRMC sentence parser. Bytes and field reads go
// in as requests on a valid/stall channel. A cycle-free model of the parser,
// kept in the bench, predicts each status and read result, and every result
// is checked in order. Directed sentences cover the header, comma-count,
// overflow and framing cases. Random sentences, mostly well formed, follow
// with random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nrmc_pkg::*;

	localparam int FCH           = FIELD_CHARS_DEF;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES   = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_GAP       = 20;
	// status, N/S, E/W, variation direction, mode
	localparam logic [NUM_FIELDS-1:0] ONE_CHAR_MASK = 13'b1100001010100;
	localparam logic [8*HDR_LEN-1:0]  HDR_TEXT = {CH_DOLLAR, CH_G, CH_P, CH_R, CH_M, CH_C};

	typedef struct packed {
		logic       kind;
		outcome_t   outcome;
		logic [3:0] commas;
		logic [7:0] chr;
		logic [4:0] len;
	} parser_result_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       action = ACT_PUSH;
	logic [7:0] byte_in = 8'h00;
	logic [3:0] field_sel = 4'd0;
	logic [3:0] char_sel = 4'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       kind;
	logic [1:0] outcome;
	logic [3:0] commas_seen;
	logic [7:0] char_out;
	logic [4:0] field_length;

	nmea_rmc_sentence_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.byte_in      (byte_in),
		.field_sel    (field_sel),
		.char_sel     (char_sel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.outcome      (outcome),
		.commas_seen  (commas_seen),
		.char_out     (char_out),
		.field_length (field_length)
	);

	// parser model state
	logic [7:0] fld_mem [NUM_BANKS][NUM_FIELDS][FCH];
	logic [4:0] fld_len [NUM_BANKS][NUM_FIELDS];
	logic       com_bank = 1'b0;
	logic       in_snt = 1'b0;
	logic [3:0] cur_fld = 4'd0;
	logic [4:0] chr_pos = 5'd0;
	outcome_t   err = OUT_OK;

	parser_result_t due_reports [$];
	parser_result_t want_rep;
	int fail_count = 0;
	int items_done = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	initial begin
		for (int b = 0; b < NUM_BANKS; b++)
			for (int f = 0; f < NUM_FIELDS; f++)
				fld_len[b][f] = '0;
	end

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// output stall: random idling, or a long hold when requested
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic flag(input string what, input int want, input int got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_reports.size() == 0) begin
				flag("result with none due", -1, int'(kind));
			end else begin
				want_rep = due_reports.pop_front();
				if (kind !== want_rep.kind)
					flag("kind", want_rep.kind, kind);
				if (outcome !== want_rep.outcome)
					flag("outcome", want_rep.outcome, outcome);
				if (commas_seen !== want_rep.commas)
					flag("commas_seen", want_rep.commas, commas_seen);
				if (char_out !== want_rep.chr)
					flag("char_out", want_rep.chr, char_out);
				if (field_length !== want_rep.len)
					flag("field_length", want_rep.len, field_length);
			end
		end
	end

	task automatic put_char(input logic [3:0] f, input logic [4:0] p, input logic [7:0] c);
		fld_mem[~com_bank][f][p] = c;
		fld_len[~com_bank][f] = p + 5'd1;
	endtask

	task automatic raise_error(input outcome_t code);
		if (err == OUT_OK)
			err = code;
	endtask

	// header must have all six characters once it is left
	task automatic close_header();
		if (cur_fld == 4'd0 && chr_pos < HDR_LEN)
			raise_error(OUT_BAD_HDR);
	endtask

	// advance the parser model by one accepted request
	task automatic apply_request(input logic act, input logic [7:0] b, input logic [3:0] fs,
			input logic [3:0] cs, output bit counted);
		parser_result_t r;
		outcome_t oc;
		r = '0;
		counted = 1'b1;
		if (act == ACT_READ) begin
			r.kind = KIND_READ;
			if (fs < NUM_FIELDS) begin
				r.len = fld_len[com_bank][fs];
				if (cs < r.len)
					r.chr = fld_mem[com_bank][fs][cs];
			end
			due_reports.push_back(r);
		end else if (b == CH_DOLLAR) begin
			for (int f = 0; f < NUM_FIELDS; f++)
				fld_len[~com_bank][f] = '0;
			in_snt = 1'b1;
			cur_fld = 4'd0;
			err = OUT_OK;
			put_char(4'd0, 5'd0, b);
			chr_pos = 5'd1;
		end else if (!in_snt) begin
			counted = 1'b0;
		end else if (b == CH_COMMA) begin
			close_header();
			if (cur_fld >= NUM_FIELDS - 1) begin
				raise_error(OUT_COMMAS);
				cur_fld = 4'(NUM_FIELDS);
			end else begin
				cur_fld++;
			end
			chr_pos = 5'd0;
		end else if (b == CH_STAR) begin
			close_header();
			if (err != OUT_OK)
				oc = err;
			else if (cur_fld != MIN_COMMAS && cur_fld != MAX_COMMAS)
				oc = OUT_COMMAS;
			else
				oc = OUT_OK;
			if (oc == OUT_OK)
				com_bank = ~com_bank;
			r.kind = KIND_STATUS;
			r.outcome = oc;
			r.commas = cur_fld;
			due_reports.push_back(r);
			in_snt = 1'b0;
			cur_fld = 4'd0;
			chr_pos = 5'd0;
			err = OUT_OK;
		end else if (cur_fld < NUM_FIELDS) begin
			if (ONE_CHAR_MASK[cur_fld]) begin
				put_char(cur_fld, 5'd0, b);
				chr_pos = 5'd1;
			end else begin
				if (cur_fld == 4'd0) begin
					if (chr_pos >= HDR_LEN)
						raise_error(OUT_BAD_HDR);
					else if (b != HDR_TEXT[8*(HDR_LEN-1-int'(chr_pos)) +: 8])
						raise_error(OUT_BAD_HDR);
				end
				if (chr_pos >= FCH) begin
					raise_error(OUT_OVERFLOW);
				end else begin
					put_char(cur_fld, chr_pos, b);
					chr_pos++;
				end
			end
		end
	endtask

	// offer one request, holding it until accepted
	task automatic send_req(input logic act, input logic [7:0] b, input logic [3:0] fs,
			input logic [3:0] cs);
		int gap;
		bit counted;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			if (in_valid)
				in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (!in_valid)
			in_valid <= 1'b1;
		action <= act;
		byte_in <= b;
		field_sel <= fs;
		char_sel <= cs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_request(act, b, fs, cs, counted);
		if (counted)
			items_done++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		send_req(ACT_PUSH, b, 4'($urandom), 4'($urandom));
	endtask

	task automatic read_field(input logic [3:0] fs, input logic [3:0] cs);
		send_req(ACT_READ, 8'($urandom), fs, cs);
	endtask

	task automatic push_text(input string s);
		for (int k = 0; k < s.len(); k++)
			push_byte(s[k]);
	endtask

	task automatic push_repeat(input logic [7:0] b, input int n);
		repeat (n) push_byte(b);
	endtask

	// sender goes quiet until every result due has come back
	task automatic drain_reports();
		if (in_valid)
			in_valid <= 1'b0;
		do
			@(posedge clk);
		while (due_reports.size() != 0);
	endtask

	task automatic read_some(input int n);
		logic [3:0] fs;
		logic [3:0] cs;
		int held;
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				fs = 4'($urandom_range(NUM_FIELDS, 15));
			else
				fs = 4'($urandom_range(0, NUM_FIELDS - 1));
			held = (fs < NUM_FIELDS) ? int'(fld_len[com_bank][fs]) : 0;
			if (held != 0 && $urandom_range(0, 3) != 0)
				cs = 4'($urandom_range(0, held - 1));
			else
				cs = 4'($urandom_range(0, 15));
			read_field(fs, cs);
		end
	endtask

	function automatic logic [7:0] random_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 1) != 0)
				c = 8'($urandom_range(8'h30, 8'h5A));
			else
				c = 8'($urandom);
		end while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA);
		return c;
	endfunction

	// mostly well-formed sentences with random content; the rest are damaged
	task automatic send_random_sentence();
		logic [7:0] line_q [$];
		int shape;
		int ncommas;
		int width;
		int spot;
		shape = $urandom_range(0, 99);
		ncommas = $urandom_range(MIN_COMMAS, MAX_COMMAS);
		if (shape >= 90)
			ncommas = $urandom_range(0, 14);
		if (shape >= 80 && shape < 85) begin
			// abandoned start, restarted by the next dollar
			line_q.push_back(CH_DOLLAR);
			repeat ($urandom_range(0, 10))
				line_q.push_back(($urandom_range(0, 3) == 0) ? CH_COMMA : random_char());
		end
		for (int k = 0; k < HDR_LEN; k++)
			line_q.push_back(HDR_TEXT[8*(HDR_LEN-1-k) +: 8]);
		if (shape >= 85 && shape < 90) begin
			case ($urandom_range(0, 2))
				0: begin
					spot = line_q.size() - $urandom_range(1, HDR_LEN - 1);
					line_q[spot] = random_char();
				end
				1: void'(line_q.pop_back());
				default: line_q.push_back(random_char());
			endcase
		end
		for (int f = 1; f <= ncommas; f++) begin
			line_q.push_back(CH_COMMA);
			if (f >= NUM_FIELDS || ONE_CHAR_MASK[f]) begin
				width = $urandom_range(0, 2);
			end else begin
				spot = $urandom_range(0, 99);
				if (spot < 4)
					width = FCH;
				else if (spot < 7)
					width = $urandom_range(FCH + 1, FCH + 3);
				else
					width = $urandom_range(0, 6);
			end
			repeat (width)
				line_q.push_back(random_char());
		end
		line_q.push_back(CH_STAR);
		// checksum and line end land outside the sentence
		if ($urandom_range(0, 1) != 0) begin
			line_q.push_back(random_char());
			line_q.push_back(random_char());
			line_q.push_back(8'h0D);
			line_q.push_back(8'h0A);
		end
		foreach (line_q[k])
			push_byte(line_q[k]);
	endtask

	task automatic test_reset_state();
		read_field(4'd0, 4'd0);
		read_field(4'd12, 4'd15);
		read_field(4'd13, 4'd0);
		read_field(4'd15, 4'd15);
	endtask

	task automatic test_full_sentence();
		push_text("$GPRMC,123519.00,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W,A*6A\r\n");
		for (int f = 0; f < 16; f++) begin
			read_field(4'(f), 4'd0);
			read_field(4'(f), 4'($urandom_range(1, 15)));
		end
	endtask

	task automatic test_comma_counts();
		push_text("$GPRMC");
		push_repeat(CH_COMMA, MIN_COMMAS);
		push_byte(CH_STAR);
		read_field(4'd12, 4'd0);
		read_field(4'd0, 4'd5);
		push_text("$GPRMC,X");
		push_repeat(CH_COMMA, 9);
		push_byte(CH_STAR);
		// characters after the thirteenth comma are dropped
		push_text("$GPRMC");
		push_repeat(CH_COMMA, 13);
		push_text("XYZ*");
		push_text("$GPRMC");
		push_repeat(CH_COMMA, 14);
		push_byte(CH_STAR);
		read_field(4'd12, 4'd0);
	endtask

	task automatic test_header_errors();
		push_text("$GPRMX");
		push_repeat(CH_COMMA, MIN_COMMAS);
		push_byte(CH_STAR);
		push_text("$GPR");
		push_repeat(CH_COMMA, MAX_COMMAS);
		push_byte(CH_STAR);
		push_text("$GPRMCA");
		push_repeat(CH_COMMA, MAX_COMMAS);
		push_byte(CH_STAR);
		push_text("$*");
		read_field(4'd0, 4'd3);
	endtask

	task automatic test_field_limits();
		push_text("$GPRMC,0123456789ABCDEF,AVZ");
		push_repeat(CH_COMMA, 10);
		push_text("N*");
		read_field(4'd1, 4'd15);
		read_field(4'd2, 4'd0);
		read_field(4'd2, 4'd1);
		read_field(4'd12, 4'd0);
		push_text("$GPRMC,,,");
		push_byte(8'h00);
		push_byte(8'hFF);
		push_repeat(CH_COMMA, 10);
		push_byte(CH_STAR);
		read_field(4'd3, 4'd0);
		read_field(4'd3, 4'd1);
		// one character past the field limit
		push_text("$GPRMC,0123456789ABCDEFG");
		push_repeat(CH_COMMA, 11);
		push_byte(CH_STAR);
		read_field(4'd3, 4'd1);
	endtask

	task automatic test_framing();
		push_text("GPRMC,*,**");
		push_byte(8'hFF);
		push_text("$GPRMC,1,2$GPRMC");
		push_repeat(CH_COMMA, MAX_COMMAS);
		push_byte(CH_STAR);
		read_field(4'd1, 4'd0);
		read_field(4'd0, 4'd5);
	endtask

	task automatic test_output_hold();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req <= hold_req + 1;
		read_some(24);
		drain_reports();
	endtask

	task automatic test_random_traffic(input int sp, input int rp, input int n);
		int first;
		send_idle_pct = sp;
		recv_idle_pct = rp;
		first = items_done;
		while (items_done - first < n) begin
			send_random_sentence();
			read_some($urandom_range(2, 8));
		end
		drain_reports();
	endtask

	initial begin
		send_idle_pct = 33;
		recv_idle_pct = 45;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_full_sentence();
		test_comma_counts();
		test_header_errors();
		test_field_limits();
		test_framing();
		drain_reports();
		test_output_hold();
		test_random_traffic(33, 45, 280);
		test_random_traffic(45, 33, 280);
		test_random_traffic(0, 0, 280);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_reports.size() != 0)
			flag("results never seen", due_reports.size(), 0);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
